// ----- rtl/sfr_pkg.sv -----
// sfr_pkg: constants, register indexes and shared types for the serial frame receiver
// used by sfr_parser and serial_frame_receiver_sum16_core; no dependencies

package sfr_pkg;

    localparam int FRAME_BYTES   = 10;
    localparam int PAYLOAD_LEN   = 5;
    localparam int PAYLOAD_FIRST = 3;
    localparam int POS_W         = 6;
    localparam int SUM_W         = 16;
    localparam int PAY_IDX_W     = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_ID      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_CODE   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd3;

    localparam logic [15:0] TIMEOUT_RESET = 16'd100;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] NIBBLE_MASK = 8'h0f;

    typedef struct packed {
        logic [7:0]  sync_byte;
        logic [7:0]  frame_id;
        logic [7:0]  length_code;
        logic [15:0] timeout_ticks;
    } sfr_cfg_t;

    typedef struct packed {
        logic        frame_ok;
        logic [7:0]  mode;
        logic [3:0]  test_progress;
        logic [3:0]  test_step;
        logic [7:0]  software_version;
        logic [7:0]  spare_first;
        logic [7:0]  spare_second;
        logic        test_mode;
        logic        comm_error;
    } sfr_result_t;

endpackage

// ----- rtl/sfr_parser.sv -----
// sfr_parser: frame hunt, running 16-bit sum, payload capture and timeout counter
// depends on sfr_pkg; one accepted beat is fully processed in the cycle it arrives

module sfr_parser
    import sfr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               beat_en,
    input  logic               kind,
    input  logic [7:0]         rx_byte,
    input  sfr_cfg_t           cfg,
    output sfr_result_t        result
);

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [SUM_W-1:0]     tcount_reg, tcount_next, tcount_inc;
    logic                 test_mode_reg, test_mode_next;
    logic                 error_reg, error_next;
    logic [7:0]           cs_high_reg;
    logic [7:0]           pending_reg [PAYLOAD_LEN];
    logic [7:0]           published_reg [PAYLOAD_LEN];
    logic                 cs_high_we;
    logic                 pending_we;
    logic                 publish;
    logic [POS_W-1:0]     pay_off;
    logic [PAY_IDX_W-1:0] pay_idx;
    logic [7:0]           pub_view [PAYLOAD_LEN];

    assign tcount_inc = tcount_reg + SUM_W'(1);
    assign pay_off    = pos_reg - POS_W'(PAYLOAD_FIRST);
    assign pay_idx    = pay_off[PAY_IDX_W-1:0];

    always_comb begin
        pos_next       = pos_reg;
        sum_next       = sum_reg;
        tcount_next    = tcount_reg;
        test_mode_next = test_mode_reg;
        error_next     = error_reg;
        cs_high_we     = 1'b0;
        pending_we     = 1'b0;
        publish        = 1'b0;
        if (kind == KIND_TICK) begin
            tcount_next = tcount_inc;
            if (tcount_inc >= cfg.timeout_ticks) begin
                tcount_next    = '0;
                pos_next       = '0;
                error_next     = 1'b1;
                test_mode_next = 1'b0;
            end
        end else if (pos_reg == POS_W'(0)) begin
            pos_next = (rx_byte == cfg.sync_byte) ? POS_W'(1) : POS_W'(0);
        end else if (pos_reg == POS_W'(1)) begin
            if (rx_byte != cfg.frame_id) begin
                pos_next = '0;
            end else begin
                sum_next = SUM_W'(rx_byte);
                pos_next = POS_W'(2);
            end
        end else if (pos_reg == POS_W'(2)) begin
            if (rx_byte != cfg.length_code) begin
                pos_next = '0;
            end else begin
                sum_next = sum_reg + SUM_W'(rx_byte);
                pos_next = POS_W'(3);
            end
        end else if (pos_reg == POS_W'(FRAME_BYTES - 1)) begin
            if ({cs_high_reg, rx_byte} == sum_reg) begin
                publish        = 1'b1;
                test_mode_next = 1'b1;
                error_next     = 1'b0;
                tcount_next    = '0;
            end
            pos_next = '0;
        end else if (pos_reg == POS_W'(FRAME_BYTES - 2)) begin
            cs_high_we = 1'b1;
            pos_next   = pos_reg + POS_W'(1);
        end else if (pos_reg < POS_W'(FRAME_BYTES - 2)) begin
            pending_we = (pos_reg >= POS_W'(PAYLOAD_FIRST)) &&
                         (pos_reg < POS_W'(PAYLOAD_FIRST + PAYLOAD_LEN));
            sum_next   = sum_reg + SUM_W'(rx_byte);
            pos_next   = pos_reg + POS_W'(1);
        end else begin
            pos_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            sum_reg       <= '0;
            tcount_reg    <= '0;
            test_mode_reg <= 1'b0;
            error_reg     <= 1'b0;
            for (int i = 0; i < PAYLOAD_LEN; i++) begin
                published_reg[i] <= '0;
            end
        end else if (beat_en) begin
            pos_reg       <= pos_next;
            sum_reg       <= sum_next;
            tcount_reg    <= tcount_next;
            test_mode_reg <= test_mode_next;
            error_reg     <= error_next;
            if (publish) begin
                for (int i = 0; i < PAYLOAD_LEN; i++) begin
                    published_reg[i] <= pending_reg[i];
                end
            end
        end
    end

    // frame scratch, always written before it is read within a frame
    always_ff @(posedge aclk) begin
        if (beat_en && cs_high_we) begin
            cs_high_reg <= rx_byte;
        end
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            if (beat_en && pending_we && (pay_idx == PAY_IDX_W'(i))) begin
                pending_reg[i] <= rx_byte;
            end
        end
    end

    // result shows the state after this beat
    always_comb begin
        for (int i = 0; i < PAYLOAD_LEN; i++) begin
            pub_view[i] = publish ? pending_reg[i] : published_reg[i];
        end
    end

    always_comb begin
        result.frame_ok         = publish;
        result.mode             = pub_view[0];
        result.test_progress    = 4'(pub_view[1] & NIBBLE_MASK);
        result.test_step        = 4'((pub_view[1] >> 4) & NIBBLE_MASK);
        result.software_version = pub_view[2];
        result.spare_first      = pub_view[3];
        result.spare_second     = pub_view[4];
        result.test_mode        = test_mode_next;
        result.comm_error       = error_next;
    end

endmodule

// ----- rtl/serial_frame_receiver_sum16_core.sv -----
// serial_frame_receiver_sum16_core: top level with config registers, stream ports and
// the result register; depends on sfr_pkg and sfr_parser
//
// Usage:
//   s_ channel: one beat per received uart byte (s_tuser = 0) or per timer tick
//   (s_tuser = 1). Every accepted beat yields exactly one result beat on m_.
//   m_ channel: m_tuser carries frame_ok, set on the beat that closed a frame
//   with a matching checksum; m_tdata carries the payload of the last good
//   frame and the test_mode and comm_error flags as they stand after the beat.
//   m_tvalid rises in the cycle after input acceptance; throughput is one
//   beat per cycle while m_tready stays high, set by the single result register.
//   When the receiver stalls (m_tvalid high, m_tready low) s_tready drops and
//   the held result stays in place until taken.
//   Config: cfg_we writes cfg_wdata into register cfg_index (0 sync code,
//   1 frame id, 2 length code, 3 timeout ticks); write only while idle.
//   Reset (aresetn low, synchronous): hunt restarts at the sync byte, sum,
//   tick count, flags and published payload clear, timeout returns to 100,
//   the other config registers to 0, and no result is pending.

module serial_frame_receiver_sum16_core
    import sfr_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] rx_byte
    input  logic                  s_tuser,   // [0] kind
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // mode, test_progress, test_step,
                                             // software_version, spare_first,
                                             // spare_second, test_mode, comm_error
    output logic                  m_tuser,   // [0] frame_ok
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    sfr_cfg_t              cfg_reg;
    sfr_result_t           result;
    logic                  beat_en;
    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic                  m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_byte     <= '0;
            cfg_reg.frame_id      <= '0;
            cfg_reg.length_code   <= '0;
            cfg_reg.timeout_ticks <= TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SYNC_BYTE:     cfg_reg.sync_byte     <= cfg_wdata[7:0];
                CFG_FRAME_ID:      cfg_reg.frame_id      <= cfg_wdata[7:0];
                CFG_LENGTH_CODE:   cfg_reg.length_code   <= cfg_wdata[7:0];
                CFG_TIMEOUT_TICKS: cfg_reg.timeout_ticks <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign s_tready = !m_tvalid_reg || m_tready;
    assign beat_en  = s_tvalid && s_tready;

    sfr_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .beat_en (beat_en),
        .kind    (s_tuser),
        .rx_byte (s_tdata),
        .cfg     (cfg_reg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (beat_en) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (beat_en) begin
            m_tuser_reg <= result.frame_ok;
            m_tdata_reg <= {6'b0, result.comm_error, result.test_mode,
                            result.spare_second, result.spare_first,
                            result.software_version, result.test_step,
                            result.test_progress, result.mode};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef SYNTHESIS
    a_ok_sets_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[40] && !m_tdata[41]))
        else $error("good frame beat without test mode or with comm error");

    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[40] && m_tdata[41]))
        else $error("test mode and comm error both set");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result stalled");

    a_beat_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted beat produced no result");
`endif

endmodule
